FILE: hw/rtl/rsas_pkg.sv
package rsas_pkg;

    // Fixed field widths of the stream payload
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_TUSER_W = 1;

    // Bit places inside the input tuser
    localparam int TUSER_FUNC    = 0;
    localparam int TUSER_RESTART = 1;

    // Request kinds
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // Result of one search
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_result;

    // Status of the probe engine toward the top level
    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_probe_stat;

endpackage

FILE: hw/rtl/rsas_store.sv
module rsas_store #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic signed [DATA_W-1:0] i_wr_data,
    input  logic [AW-1:0]            i_rd_lo_addr,
    input  logic [AW-1:0]            i_rd_mid_addr,
    input  logic [AW-1:0]            i_rd_hi_addr,
    output logic signed [DATA_W-1:0] o_lo_data,
    output logic signed [DATA_W-1:0] o_mid_data,
    output logic signed [DATA_W-1:0] o_hi_data
);

    // Two copies of the element array: copy A serves the lo and mid reads,
    // copy B serves the hi read. Both take every write.
    logic signed [DATA_W-1:0] r_mem_a [DEPTH];
    logic signed [DATA_W-1:0] r_mem_b [DEPTH];
    logic signed [DATA_W-1:0] r_lo_data;
    logic signed [DATA_W-1:0] r_mid_data;
    logic signed [DATA_W-1:0] r_hi_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_a[i_wr_addr] <= i_wr_data;
            r_mem_b[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read ports
    always_ff @(posedge i_clk) begin
        r_lo_data  <= r_mem_a[i_rd_lo_addr];
        r_mid_data <= r_mem_a[i_rd_mid_addr];
        r_hi_data  <= r_mem_b[i_rd_hi_addr];
    end

    assign o_lo_data  = r_lo_data;
    assign o_mid_data = r_mid_data;
    assign o_hi_data  = r_hi_data;

endmodule

FILE: hw/rtl/rsas_probe.sv
module rsas_probe #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 32,
    localparam int AW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DATA_W-1:0] i_target,
    input  logic [CW-1:0]            i_count,
    input  logic                     i_res_ready,
    output logic [AW-1:0]            o_rd_lo_addr,
    output logic [AW-1:0]            o_rd_mid_addr,
    output logic [AW-1:0]            o_rd_hi_addr,
    input  logic signed [DATA_W-1:0] i_lo_data,
    input  logic signed [DATA_W-1:0] i_mid_data,
    input  logic signed [DATA_W-1:0] i_hi_data,
    output rsas_pkg::t_probe_stat    o_stat,
    output rsas_pkg::t_result        o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_EVAL,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [CW-1:0]            r_lo;     // lowest live index
    logic [CW-1:0]            r_hi_p1;  // one past the highest live index
    logic [AW-1:0]            r_mid;
    logic signed [DATA_W-1:0] r_target;
    logic                     r_found;
    logic [rsas_pkg::POS_W-1:0] r_pos;

    logic [CW-1:0]              w_span;
    logic [CW-1:0]              w_mid_full;
    logic [AW-1:0]              w_mid;
    logic [CW-1:0]              w_hi_full;
    logic                       w_live;
    logic                       w_hit;
    logic                       w_go_left;
    logic [CW-1:0]              w_mid_p1;
    logic [rsas_pkg::POS_W-1:0] w_mid_pos;

    // Probe address: mid = lo + (hi - lo) / 2, with hi = hi_p1 - 1
    always_comb begin
        w_live     = (r_lo < r_hi_p1);
        w_span     = r_hi_p1 - CW'(1) - r_lo;
        w_mid_full = r_lo + (w_span >> 1);
        w_mid      = w_mid_full[AW-1:0];
        w_hi_full  = r_hi_p1 - CW'(1);
        w_mid_p1   = CW'(r_mid) + CW'(1);
    end

    assign o_rd_lo_addr  = r_lo[AW-1:0];
    assign o_rd_mid_addr = w_mid;
    assign o_rd_hi_addr  = w_hi_full[AW-1:0];

    // Decide which half is sorted and whether it can hold the target
    always_comb begin
        w_hit = (i_mid_data == r_target);
        if (i_lo_data <= i_mid_data) begin
            w_go_left = (i_lo_data <= r_target) && (r_target < i_mid_data);
        end else begin
            w_go_left = !((i_mid_data < r_target) && (r_target <= i_hi_data));
        end
    end

    // Index reported on the narrow position field
    generate
        if (AW >= rsas_pkg::POS_W) begin : g_pos_trunc
            assign w_mid_pos = r_mid[rsas_pkg::POS_W-1:0];
        end else begin : g_pos_ext
            assign w_mid_pos = {{(rsas_pkg::POS_W - AW){1'b0}}, r_mid};
        end
    endgenerate

    // Search sequencer: issue reads, evaluate, narrow range, repeat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_lo     <= '0;
                        r_hi_p1  <= i_count;
                        r_target <= i_target;
                        r_state  <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (w_live) begin
                        r_mid   <= w_mid;
                        r_state <= S_EVAL;
                    end else begin
                        r_found <= 1'b0;
                        r_pos   <= '0;
                        r_state <= S_DONE;
                    end
                end
                S_EVAL: begin
                    if (w_hit) begin
                        r_found <= 1'b1;
                        r_pos   <= w_mid_pos;
                        r_state <= S_DONE;
                    end else begin
                        if (w_go_left) begin
                            r_hi_p1 <= CW'(r_mid);
                        end else begin
                            r_lo <= w_mid_p1;
                        end
                        r_state <= S_ISSUE;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stat.idle      = (r_state == S_IDLE);
    assign o_stat.res_valid = (r_state == S_DONE);
    assign o_result.found    = r_found;
    assign o_result.position = r_pos;

endmodule

FILE: hw/rtl/rotated_sorted_array_search_core.sv
// Channel   Direction  tdata (low bit up)            tuser (low bit up)
// s_axis    in         value[31:0]                   func, restart
// m_axis    out        position[5:0], 2'b0           found
//
// An append yields no result.
// A search makes P probes, P <= log2(DEPTH)+1; each probe reads the element memory
// in S_ISSUE and compares the read words in S_EVAL.
// Its result passes from the engine's S_DONE state into the output register on m_axis;
// the engine takes the next request once it has returned to idle.
// Reset clears the element count; the element memory is not cleared.
// A result held by m_axis_tready waits in the output register while requests go on;
// a second finished result holds the engine, and so the input, until it frees.
module rotated_sorted_array_search_core #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [rsas_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // value
    input  logic [rsas_pkg::IN_TUSER_W-1:0]      s_axis_tuser,  // func, restart
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [rsas_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // position, pad
    output logic [rsas_pkg::OUT_TUSER_W-1:0]     m_axis_tuser   // found
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                     w_in_acc;
    logic                     w_append;
    logic                     w_search;
    logic                     w_restart;
    logic signed [DATA_W-1:0] w_value;
    logic                     w_wr_en;
    logic [AW-1:0]            w_wr_addr;
    logic                     w_out_free;
    logic [AW-1:0]            w_rd_lo_addr;
    logic [AW-1:0]            w_rd_mid_addr;
    logic [AW-1:0]            w_rd_hi_addr;
    logic signed [DATA_W-1:0] w_lo_data;
    logic signed [DATA_W-1:0] w_mid_data;
    logic signed [DATA_W-1:0] w_hi_data;
    rsas_pkg::t_probe_stat    w_stat;
    rsas_pkg::t_result        w_result;

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_out_valid;
    rsas_pkg::t_result r_out;

    // Input decode
    assign s_axis_tready = w_stat.idle;
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_append  = w_in_acc && (s_axis_tuser[rsas_pkg::TUSER_FUNC] == rsas_pkg::FUNC_APPEND);
    assign w_search  = w_in_acc && (s_axis_tuser[rsas_pkg::TUSER_FUNC] == rsas_pkg::FUNC_SEARCH);
    assign w_restart = s_axis_tuser[rsas_pkg::TUSER_RESTART];

    // Value to element word: sign-extend or truncate
    generate
        if (DATA_W > rsas_pkg::VALUE_W) begin : g_val_ext
            assign w_value = {{(DATA_W - rsas_pkg::VALUE_W){s_axis_tdata[rsas_pkg::VALUE_W-1]}},
                              s_axis_tdata};
        end else begin : g_val_trunc
            assign w_value = s_axis_tdata[DATA_W-1:0];
        end
    endgenerate

    // Append: store at the fill point, or at zero on restart; a plain append is dropped when full
    always_comb begin
        w_wr_en   = w_append && (w_restart || (r_count < CW'(DEPTH)));
        w_wr_addr = w_restart ? '0 : r_count[AW-1:0];
        n_count   = w_restart ? CW'(1) : (r_count + CW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_wr_en) begin
            r_count <= n_count;
        end
    end

    rsas_store #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_store (
        .i_clk         (i_clk),
        .i_wr_en       (w_wr_en),
        .i_wr_addr     (w_wr_addr),
        .i_wr_data     (w_value),
        .i_rd_lo_addr  (w_rd_lo_addr),
        .i_rd_mid_addr (w_rd_mid_addr),
        .i_rd_hi_addr  (w_rd_hi_addr),
        .o_lo_data     (w_lo_data),
        .o_mid_data    (w_mid_data),
        .o_hi_data     (w_hi_data)
    );

    rsas_probe #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_probe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_search),
        .i_target      (w_value),
        .i_count       (r_count),
        .i_res_ready   (w_out_free),
        .o_rd_lo_addr  (w_rd_lo_addr),
        .o_rd_mid_addr (w_rd_mid_addr),
        .o_rd_hi_addr  (w_rd_hi_addr),
        .i_lo_data     (w_lo_data),
        .i_mid_data    (w_mid_data),
        .i_hi_data     (w_hi_data),
        .o_stat        (w_stat),
        .o_result      (w_result)
    );

    // Output register
    assign w_out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_stat.res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_stat.res_valid) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(rsas_pkg::OUT_TDATA_W - rsas_pkg::POS_W){1'b0}}, r_out.position};
    assign m_axis_tuser  = r_out.found;

`ifndef NO_ASSERTIONS
    // Element count never passes the array depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count beyond depth");

    // A restart append leaves exactly one element
    a_restart_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_append && w_restart) |=> (r_count == CW'(1)))
        else $error("restart did not reset the count");

    // An accepted search blocks new requests on the next cycle
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_search |=> !s_axis_tready)
        else $error("search did not occupy the engine");

    // A miss reports position zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("miss with nonzero position");
`endif

endmodule
